// ===== hw/rtl/pes_pkg.sv =====
`timescale 1ns / 1ps

package pes_pkg;

   localparam int TIME_W    = 32;
   localparam int PERIOD_W  = 16;
   localparam int OUT_IDX_W = 6;
   localparam int STATUS_W  = 2;
   localparam int ENTRY_W   = TIME_W + PERIOD_W;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_NEXT  = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic exec;
      logic scan;
      logic update;
      logic load;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_go;
      logic scan_last;
      logic out_free;
   } dp_status_type;

endpackage

// ===== hw/rtl/pes_if.sv =====
`timescale 1ns / 1ps

interface pes_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    cmd;
   logic [pes_pkg::PERIOD_W-1:0]  period;

   modport source (output valid, output cmd, output period, input ready);
   modport sink   (input valid, input cmd, input period, output ready);
endinterface

interface pes_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [pes_pkg::TIME_W-1:0]     event_time;
   logic [pes_pkg::OUT_IDX_W-1:0]  entry_index;
   logic [pes_pkg::STATUS_W-1:0]   status;

   modport source (output valid, output event_time, output entry_index, output status,
                   input ready);
   modport sink   (input valid, input event_time, input entry_index, input status,
                   output ready);
endinterface

// ===== hw/rtl/pes_ram.sv =====
`timescale 1ns / 1ps

module pes_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/pes_ctrl.sv =====
`timescale 1ns / 1ps

module pes_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pes_pkg::dp_status_type status,
   output pes_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      IDLE,
      EXEC,
      SCAN,
      UPDATE,
      RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_valid && ready_ff) state_in = EXEC;
         end
         EXEC: begin
            state_in = status.scan_go ? SCAN : RESULT;
         end
         SCAN: begin
            if (status.scan_last) state_in = UPDATE;
         end
         UPDATE: begin
            state_in = RESULT;
         end
         RESULT: begin
            if (status.out_free) state_in = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
      ready_in = (state_in == IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready  = ready_ff;
   assign cmd.take   = req_valid && ready_ff;
   assign cmd.exec   = (state_ff == EXEC);
   assign cmd.scan   = (state_ff == SCAN);
   assign cmd.update = (state_ff == UPDATE);
   assign cmd.load   = (state_ff == RESULT) && status.out_free;

endmodule

// ===== hw/rtl/pes_dp.sv =====
`timescale 1ns / 1ps

module pes_dp #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pes_pkg::ctrl_cmd_type             cmd,
   output pes_pkg::dp_status_type            status,
   input  logic [1:0]                        req_cmd,
   input  logic [pes_pkg::PERIOD_W-1:0]      req_period,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pes_pkg::TIME_W-1:0]        rsp_event_time,
   output logic [pes_pkg::OUT_IDX_W-1:0]     rsp_entry_index,
   output logic [pes_pkg::STATUS_W-1:0]      rsp_status
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int TW    = pes_pkg::TIME_W;
   localparam int PW    = pes_pkg::PERIOD_W;
   localparam int OW    = pes_pkg::OUT_IDX_W;

   // latched command
   logic [1:0]    cmd_ff;
   logic [PW-1:0] period_ff;

   logic [CNT_W-1:0] count_ff;

   // scan state
   logic [IDX_W-1:0] issue_ff;
   logic [IDX_W-1:0] chk_ff;
   logic             first_ff;
   logic [TW-1:0]    best_time_ff;
   logic [PW-1:0]    best_period_ff;
   logic [IDX_W-1:0] best_idx_ff;

   // pending result and output register
   logic [TW-1:0]                res_time_ff;
   logic [OW-1:0]                res_idx_ff;
   logic [pes_pkg::STATUS_W-1:0] res_status_ff;
   logic                         out_valid_ff;
   logic [TW-1:0]                out_time_ff;
   logic [OW-1:0]                out_idx_ff;
   logic [pes_pkg::STATUS_W-1:0] out_status_ff;

   logic                        is_full;
   logic                        is_empty;
   logic                        add_ok;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [pes_pkg::ENTRY_W-1:0] wr_data;
   logic [pes_pkg::ENTRY_W-1:0] rd_data;
   logic [TW-1:0]               rd_time;
   logic [PW-1:0]               rd_period;
   logic                        take_rd;
   logic [TW:0]                 sum;
   logic [TW-1:0]               new_time;

   assign is_full  = (count_ff == CNT_W'(MAX_ENTRIES));
   assign is_empty = (count_ff == '0);
   assign add_ok   = cmd.exec && (cmd_ff == pes_pkg::CMD_ADD) && !is_full;

   assign rd_time   = rd_data[TW-1:0];
   assign rd_period = rd_data[pes_pkg::ENTRY_W-1:TW];
   // strict compare keeps the lower index on a tie
   assign take_rd   = first_ff || (rd_time < best_time_ff);

   assign sum      = {1'b0, best_time_ff} + {{(TW+1-PW){1'b0}}, best_period_ff};
   assign new_time = sum[TW] ? pes_pkg::TIME_MAX : sum[TW-1:0];

   assign wr_en   = add_ok || cmd.update;
   assign wr_addr = cmd.update ? best_idx_ff : count_ff[IDX_W-1:0];
   assign wr_data = cmd.update ? {best_period_ff, new_time}
                               : {period_ff, {(TW-PW){1'b0}}, period_ff};

   pes_ram #(
      .WIDTH (pes_pkg::ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (issue_ff),
      .rd_data (rd_data)
   );

   assign status.scan_go   = (cmd_ff == pes_pkg::CMD_NEXT) && !is_empty;
   assign status.scan_last = (CNT_W'(chk_ff) == count_ff - CNT_W'(1));
   assign status.out_free  = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         cmd_ff    <= req_cmd;
         period_ff <= req_period;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         if (cmd_ff == pes_pkg::CMD_CLEAR) begin
            count_ff <= '0;
         end else if (add_ok) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   // read address runs one entry ahead of the compare
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= '0;
         chk_ff   <= '0;
         first_ff <= 1'b0;
      end else if (cmd.take) begin
         issue_ff <= '0;
      end else if (cmd.exec) begin
         issue_ff <= IDX_W'(1);
         chk_ff   <= '0;
         first_ff <= 1'b1;
      end else if (cmd.scan) begin
         issue_ff <= issue_ff + IDX_W'(1);
         chk_ff   <= chk_ff + IDX_W'(1);
         first_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan && take_rd) begin
         best_time_ff   <= rd_time;
         best_period_ff <= rd_period;
         best_idx_ff    <= chk_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         res_time_ff   <= '0;
         res_idx_ff    <= '0;
         res_status_ff <= pes_pkg::STATUS_OK;
         case (cmd_ff)
            pes_pkg::CMD_ADD: begin
               if (is_full) begin
                  res_status_ff <= pes_pkg::STATUS_FULL;
               end else begin
                  res_idx_ff <= OW'({{OW{1'b0}}, count_ff[IDX_W-1:0]});
               end
            end
            pes_pkg::CMD_NEXT: begin
               if (is_empty) res_status_ff <= pes_pkg::STATUS_EMPTY;
            end
            default: begin
            end
         endcase
      end else if (cmd.update) begin
         res_time_ff   <= best_time_ff;
         res_idx_ff    <= OW'({{OW{1'b0}}, best_idx_ff});
         res_status_ff <= pes_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_time_ff   <= res_time_ff;
         out_idx_ff    <= res_idx_ff;
         out_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_event_time  = out_time_ff;
   assign rsp_entry_index = out_idx_ff;
   assign rsp_status      = out_status_ff;

endmodule

// ===== hw/rtl/periodic_event_scheduler_unit.sv =====
`timescale 1ns / 1ps
// periodic event scheduler
// req_bus carries one command per transaction: clear, add (with a period) or next.
// rsp_bus returns exactly one transaction per command: event time, entry index, status.
// entries live in a single-port-write, registered-read ram of MAX_ENTRIES words.
// steps from request acceptance to response valid:
//   clear, add, unused code, next on an empty table: exec, then the result load
//   next: exec, then a linear scan that reads one entry per cycle from the ram,
//   followed by a write-back step for the advanced time, then the result load
// one command is handled at a time; req_bus.ready is high only while idle.
// the response sits in an output register, so a new request is taken while an
// earlier response still waits; if the receiver stalls, the block holds the next
// result and waits before going idle again.
// reset (synchronous) empties the table and drops rsp_bus.valid; the ram contents
// are left as they are, as only entries below the count are ever read.
module periodic_event_scheduler_unit #(
   parameter int MAX_ENTRIES = 64
) (
   input logic        clock,
   input logic        reset,
   pes_req_if.sink    req_bus,
   pes_rsp_if.source  rsp_bus
);

   pes_pkg::ctrl_cmd_type  ctrl_cmd;
   pes_pkg::dp_status_type dp_status;

   pes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   pes_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (ctrl_cmd),
      .status          (dp_status),
      .req_cmd         (req_bus.cmd),
      .req_period      (req_bus.period),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_event_time  (rsp_bus.event_time),
      .rsp_entry_index (rsp_bus.entry_index),
      .rsp_status      (rsp_bus.status)
   );

endmodule

// ===== hw/rtl/pes_checker.sv =====
`timescale 1ns / 1ps

module pes_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [pes_pkg::TIME_W-1:0]        rsp_event_time,
   input logic [pes_pkg::OUT_IDX_W-1:0]     rsp_entry_index,
   input logic [pes_pkg::STATUS_W-1:0]      rsp_status
);

   // a pending response is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // one command at a time
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != pes_pkg::STATUS_OK)
      |-> (rsp_event_time == '0) && (rsp_entry_index == '0))
      else $error("error response carries data");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_ready)
      else $error("activity straight after reset");

endmodule

bind periodic_event_scheduler_unit pes_checker u_pes_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_event_time  (rsp_bus.event_time),
   .rsp_entry_index (rsp_bus.entry_index),
   .rsp_status      (rsp_bus.status)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int          TABLE_DEPTH    = 64;
   localparam int          WATCHDOG_LIMIT = 3000;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          PHASE_ITEMS    = 300;
   localparam logic [1:0]  CMD_UNUSED     = 2'd3;

   typedef struct packed {
      logic [pes_pkg::TIME_W-1:0]    fire_time;
      logic [pes_pkg::OUT_IDX_W-1:0] slot;
      pes_pkg::status_type           status;
   } sched_result_type;

   typedef struct packed {
      logic [1:0]                   op;
      logic [pes_pkg::PERIOD_W-1:0] period;
      logic [17:0]                  reps;
      logic                         typed;
      sched_result_type             want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   pes_req_if req_bus ();
   pes_rsp_if rsp_bus ();

   periodic_event_scheduler_unit #(
      .MAX_ENTRIES(TABLE_DEPTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // scheduler image kept by the testbench
   logic [pes_pkg::TIME_W-1:0]   due_time [TABLE_DEPTH];
   logic [pes_pkg::PERIOD_W-1:0] repeat_gap [TABLE_DEPTH];
   int unsigned                  live_entries;

   sched_result_type awaited_results [$];
   int               fault_count;
   int               items_issued;
   int               idle_pct;
   int               stall_pct;
   int               hold_request;
   int               hold_left;
   int               quiet_cycles;

   // directed rows; the long run of next commands alternates two entries on the longest period
   stim_row_type directed_rows [0:19] = '{
      '{pes_pkg::CMD_NEXT,  16'h0000, 18'd1,  1'b1, '{32'd0, 6'd0, pes_pkg::STATUS_EMPTY}},
      '{CMD_UNUSED,         16'hFFFF, 18'd1,  1'b1, '{32'd0, 6'd0, pes_pkg::STATUS_OK}},
      '{pes_pkg::CMD_CLEAR, 16'h5555, 18'd1,  1'b1, '{32'd0, 6'd0, pes_pkg::STATUS_OK}},
      '{pes_pkg::CMD_ADD,   16'h0000, 18'd1,  1'b1, '{32'd0, 6'd0, pes_pkg::STATUS_OK}},
      '{pes_pkg::CMD_NEXT,  16'hAAAA, 18'd2,  1'b1, '{32'd0, 6'd0, pes_pkg::STATUS_OK}},
      '{pes_pkg::CMD_CLEAR, 16'h0000, 18'd1,  1'b1, '{32'd0, 6'd0, pes_pkg::STATUS_OK}},
      '{pes_pkg::CMD_ADD,   16'hFFFF, 18'd1,  1'b1, '{32'd0, 6'd0, pes_pkg::STATUS_OK}},
      '{pes_pkg::CMD_ADD,   16'h0001, 18'd1,  1'b1, '{32'd0, 6'd1, pes_pkg::STATUS_OK}},
      '{pes_pkg::CMD_ADD,   16'h8000, 18'd1,  1'b1, '{32'd0, 6'd2, pes_pkg::STATUS_OK}},
      '{pes_pkg::CMD_NEXT,  16'h0000, 18'd3,  1'b0, '0},
      '{pes_pkg::CMD_ADD,   16'h5555, 18'd61, 1'b0, '0},
      '{pes_pkg::CMD_ADD,   16'hAAAA, 18'd1,  1'b1, '{32'd0, 6'd0, pes_pkg::STATUS_FULL}},
      '{pes_pkg::CMD_NEXT,  16'h0000, 18'd4,  1'b0, '0},
      '{pes_pkg::CMD_CLEAR, 16'h0000, 18'd1,  1'b1, '{32'd0, 6'd0, pes_pkg::STATUS_OK}},
      '{pes_pkg::CMD_NEXT,  16'h0000, 18'd1,  1'b1, '{32'd0, 6'd0, pes_pkg::STATUS_EMPTY}},
      '{pes_pkg::CMD_ADD,   16'hFFFF, 18'd1,  1'b1, '{32'd0, 6'd0, pes_pkg::STATUS_OK}},
      '{pes_pkg::CMD_ADD,   16'hFFFF, 18'd1,  1'b1, '{32'd0, 6'd1, pes_pkg::STATUS_OK}},
      '{pes_pkg::CMD_NEXT,  16'h0000, 18'd40, 1'b0, '0},
      '{CMD_UNUSED,         16'h0000, 18'd1,  1'b1, '{32'd0, 6'd0, pes_pkg::STATUS_OK}},
      '{pes_pkg::CMD_CLEAR, 16'hFFFF, 18'd1,  1'b1, '{32'd0, 6'd0, pes_pkg::STATUS_OK}}
   };

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic sched_result_type schedule_step(
         input logic [1:0] op, input logic [pes_pkg::PERIOD_W-1:0] gap);
      sched_result_type           r;
      int unsigned                pick;
      logic [pes_pkg::TIME_W:0]   sum;
      r = '{fire_time: '0, slot: '0, status: pes_pkg::STATUS_OK};
      case (op)
         pes_pkg::CMD_CLEAR: begin
            live_entries = 0;
         end
         pes_pkg::CMD_ADD: begin
            if (live_entries >= TABLE_DEPTH) begin
               r.status = pes_pkg::STATUS_FULL;
            end else begin
               due_time[live_entries]   = pes_pkg::TIME_W'(gap);
               repeat_gap[live_entries] = gap;
               r.slot = pes_pkg::OUT_IDX_W'(live_entries);
               live_entries++;
            end
         end
         pes_pkg::CMD_NEXT: begin
            if (live_entries == 0) begin
               r.status = pes_pkg::STATUS_EMPTY;
            end else begin
               pick = 0;
               // strict compare keeps the lower index on a tie
               for (int unsigned i = 1; i < live_entries; i++)
                  if (due_time[i] < due_time[pick]) pick = i;
               r.fire_time = due_time[pick];
               r.slot      = pes_pkg::OUT_IDX_W'(pick);
               sum = {1'b0, due_time[pick]}
                     + {{(pes_pkg::TIME_W-pes_pkg::PERIOD_W+1){1'b0}}, repeat_gap[pick]};
               due_time[pick] = sum[pes_pkg::TIME_W] ? pes_pkg::TIME_MAX
                                                     : sum[pes_pkg::TIME_W-1:0];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [pes_pkg::PERIOD_W-1:0] pick_period();
      case ($urandom_range(9))
         0:       return '0;
         1, 2:    return pes_pkg::PERIOD_W'($urandom);
         3:       return pes_pkg::PERIOD_W'(16'hFFFF - $urandom_range(3));
         default: return pes_pkg::PERIOD_W'($urandom_range(1, 40));
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after the transaction
   task automatic issue(input logic [1:0] op, input logic [pes_pkg::PERIOD_W-1:0] gap,
                        input logic typed = 1'b0, input sched_result_type want = '0);
      sched_result_type r;
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.cmd    <= op;
      req_bus.period <= gap;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      r = schedule_step(op, gap);
      awaited_results.push_back(typed ? want : r);
      items_issued++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (awaited_results.size() != 0) @(negedge clock);
   endtask

   task automatic random_traffic(input int quota);
      int first;
      int burst;
      int pick;
      first = items_issued;
      while (items_issued - first < quota) begin
         if ($urandom_range(99) < 10) begin
            // noise: any code, any period
            repeat ($urandom_range(1, 4))
               issue(2'($urandom_range(3)), pes_pkg::PERIOD_W'($urandom));
         end else begin
            issue(pes_pkg::CMD_CLEAR, pes_pkg::PERIOD_W'($urandom));
            burst = ($urandom_range(11) == 0) ? $urandom_range(TABLE_DEPTH - 4, TABLE_DEPTH + 4)
                                              : $urandom_range(1, 8);
            repeat (burst) issue(pes_pkg::CMD_ADD, pick_period());
            repeat ($urandom_range(2, 24)) begin
               pick = $urandom_range(19);
               if (pick == 0)
                  issue(pes_pkg::CMD_ADD, pick_period());
               else if (pick == 1)
                  issue(pes_pkg::CMD_CLEAR, pes_pkg::PERIOD_W'($urandom));
               else
                  issue(pes_pkg::CMD_NEXT, pes_pkg::PERIOD_W'($urandom));
            end
         end
      end
   endtask

   task automatic note_mismatch(input string field, input logic [pes_pkg::TIME_W-1:0] want,
                                input logic [pes_pkg::TIME_W-1:0] got);
      fault_count++;
      if (fault_count <= 40)
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
   endtask

   // receiver: random stalls plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_results.size() == 0) begin
            fault_count++;
            $display("%0t: response transaction with nothing outstanding, actual %0h %0h %0h",
                     $time, rsp_bus.event_time, rsp_bus.entry_index, rsp_bus.status);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_bus.event_time !== want.fire_time)
               note_mismatch("event_time", want.fire_time, rsp_bus.event_time);
            if (rsp_bus.entry_index !== want.slot)
               note_mismatch("entry_index", pes_pkg::TIME_W'(want.slot),
                             pes_pkg::TIME_W'(rsp_bus.entry_index));
            if (rsp_bus.status !== want.status)
               note_mismatch("status", pes_pkg::TIME_W'(want.status),
                             pes_pkg::TIME_W'(rsp_bus.status));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.cmd    = pes_pkg::CMD_CLEAR;
      req_bus.period = '0;
      rsp_bus.ready  = 1'b0;
      live_entries   = 0;
      fault_count    = 0;
      items_issued   = 0;
      idle_pct       = 0;
      stall_pct      = 0;
      hold_request   = 0;
      hold_left      = 0;
      quiet_cycles   = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[n])
         repeat (directed_rows[n].reps)
            issue(directed_rows[n].op, directed_rows[n].period,
                  directed_rows[n].typed, directed_rows[n].want);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = (phase == 1) ? 70 : (phase == 3) ? 14 : 0;
         stall_pct = (phase == 2) ? 70 : (phase == 3) ? 14 : 0;
         // long receiver hold-off while requests keep coming, so the input backs up
         if (phase == 0) hold_request = HOLD_CYCLES;
         random_traffic(PHASE_ITEMS);
         drain();
      end

      repeat (TABLE_DEPTH + 16) @(posedge clock);
      if (fault_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== periodic_event_scheduler_unit.f =====
hw/rtl/pes_pkg.sv
hw/rtl/pes_if.sv
hw/rtl/pes_ram.sv
hw/rtl/pes_ctrl.sv
hw/rtl/pes_dp.sv
hw/rtl/periodic_event_scheduler_unit.sv
hw/rtl/pes_checker.sv
test/testbench.sv
